### design/eos_pkg.sv
// Shared types and constants for the operand stack unit.
`default_nettype none

package eos_pkg;

   // Fixed field widths of the item channels.
   localparam int OP_W       = 3;
   localparam int IDX_W      = 10;
   localparam int WORD_W     = 64;
   localparam int WORDS      = 4;
   localparam int VALUE_W    = WORD_W * WORDS;
   localparam int STATUS_W   = 3;
   localparam int DEPTH_W    = 11;

   // Default number of stack entries.
   localparam int DEPTH_DEFAULT = 1024;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_NARROW = 3'd2,
      OP_SWAP   = 3'd3,
      OP_DUP    = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_UNDER = 3'd1,
      ST_OVER  = 3'd2,
      ST_INDEX = 3'd3,
      ST_WIDE  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_SWAP_RD,
      S_SWAP_WR,
      S_SWAP_FIN,
      S_DUP
   } state_type;

   // One finished result as handed from the sequencer to the output register.
   typedef struct packed {
      logic [WORDS-1:0][WORD_W-1:0] data;
      status_type                   status;
      logic [DEPTH_W-1:0]           depth;
   } result_type;

endpackage

`default_nettype wire

### design/eos_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module eos_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/eos_ctrl.sv
// Sequencer for the operand stack: entry count, bounds checks and RAM accesses.
`default_nettype none

module eos_ctrl #(
   parameter int STACK_DEPTH = eos_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire eos_pkg::op_type                     req_op,
   input  wire logic [eos_pkg::IDX_W-1:0]           req_index,
   input  wire logic [eos_pkg::VALUE_W-1:0]         req_value,
   input  wire logic                                rsp_free,
   output logic                                     res_load,
   output eos_pkg::result_type                      res,
   output logic                                     ram_wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0]           ram_wr_addr,
   output logic [eos_pkg::VALUE_W-1:0]              ram_wr_data,
   output logic                                     ram_rd_en,
   output logic [$clog2(STACK_DEPTH)-1:0]           ram_rd_addr,
   input  wire logic [eos_pkg::VALUE_W-1:0]         ram_rd_data
);

   import eos_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int WW = (CW > IDX_W) ? CW : IDX_W;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                narrow_ff, narrow_in;
   logic [AW-1:0]       top_addr_ff, top_addr_in;
   logic [AW-1:0]       other_addr_ff, other_addr_in;
   logic [VALUE_W-1:0]  hold_ff, hold_in;

   logic                accept;
   logic                full;
   logic [WW-1:0]       idx_w;
   logic [WW-1:0]       cnt_w;
   logic [WW-1:0]       top_w;
   logic [WW-1:0]       other_w;
   logic                idx_beyond;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Addresses and the swap holding register carry no reset.
   always_ff @(posedge clock) begin
      narrow_ff     <= narrow_in;
      top_addr_ff   <= top_addr_in;
      other_addr_ff <= other_addr_in;
      hold_ff       <= hold_in;
   end

   // Index arithmetic, all in one common width.
   always_comb begin
      idx_w      = WW'(req_index);
      cnt_w      = WW'(count_ff);
      top_w      = cnt_w - WW'(1);
      other_w    = top_w - idx_w;
      idx_beyond = (idx_w >= cnt_w);
      full       = (count_ff == CW'(STACK_DEPTH));
   end

   // Next state, RAM commands and results.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      narrow_in     = narrow_ff;
      top_addr_in   = top_addr_ff;
      other_addr_in = other_addr_ff;
      hold_in       = hold_ff;
      req_stall     = 1'b1;
      accept        = 1'b0;
      res_load      = 1'b0;
      res           = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = top_addr_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = top_w[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            req_stall = !rsp_free;
            accept    = req_valid && rsp_free;
            if (accept) begin
               unique case (req_op)
                  OP_PUSH: begin
                     res_load = 1'b1;
                     if (full) begin
                        res.status = ST_OVER;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[AW-1:0];
                        ram_wr_data = req_value;
                        count_in    = count_ff + CW'(1);
                     end
                     res.depth = DEPTH_W'(count_in);
                  end
                  OP_POP, OP_NARROW: begin
                     if (count_ff == '0) begin
                        res_load   = 1'b1;
                        res.status = ST_UNDER;
                        res.depth  = DEPTH_W'(count_ff);
                     end else begin
                        ram_rd_en = 1'b1;
                        count_in  = count_ff - CW'(1);
                        narrow_in = (req_op == OP_NARROW);
                        state_in  = S_POP;
                     end
                  end
                  OP_SWAP: begin
                     if (req_index == '0 || idx_beyond) begin
                        res_load   = 1'b1;
                        res.status = ST_INDEX;
                        res.depth  = DEPTH_W'(count_ff);
                     end else begin
                        ram_rd_en     = 1'b1;
                        top_addr_in   = top_w[AW-1:0];
                        other_addr_in = other_w[AW-1:0];
                        state_in      = S_SWAP_RD;
                     end
                  end
                  OP_DUP: begin
                     if (idx_beyond) begin
                        res_load   = 1'b1;
                        res.status = ST_INDEX;
                        res.depth  = DEPTH_W'(count_ff);
                     end else if (full) begin
                        res_load   = 1'b1;
                        res.status = ST_OVER;
                        res.depth  = DEPTH_W'(count_ff);
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = other_w[AW-1:0];
                        state_in    = S_DUP;
                     end
                  end
                  default: begin
                     // Unused op codes report ok and leave the stack alone.
                     res_load  = 1'b1;
                     res.depth = DEPTH_W'(count_ff);
                  end
               endcase
            end
         end

         // Read data of the popped entry is ready; the count already dropped.
         S_POP: begin
            res_load  = 1'b1;
            res.depth = DEPTH_W'(count_ff);
            if (!narrow_ff) begin
               res.data = ram_rd_data;
            end else if (|ram_rd_data[VALUE_W-1:WORD_W]) begin
               res.status = ST_WIDE;
            end else begin
               res.data[0] = ram_rd_data[WORD_W-1:0];
            end
            state_in = S_IDLE;
         end

         // Top entry arrives: keep it and read the deeper entry.
         S_SWAP_RD: begin
            hold_in     = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = other_addr_ff;
            state_in    = S_SWAP_WR;
         end

         // Deeper entry arrives: it goes to the top slot.
         S_SWAP_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = top_addr_ff;
            ram_wr_data = ram_rd_data;
            state_in    = S_SWAP_FIN;
         end

         // Old top goes to the deeper slot and the item completes.
         S_SWAP_FIN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = other_addr_ff;
            ram_wr_data = hold_ff;
            res_load    = 1'b1;
            res.depth   = DEPTH_W'(count_ff);
            state_in    = S_IDLE;
         end

         // Copied entry arrives and is written above the top.
         S_DUP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = count_ff[AW-1:0];
            ram_wr_data = ram_rd_data;
            count_in    = count_ff + CW'(1);
            res_load    = 1'b1;
            res.depth   = DEPTH_W'(count_in);
            state_in    = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/evm_operand_stack_unit.sv
// Top level of the 256-bit operand stack unit: RAM, sequencer and result register.
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_stall   op, index, value_w0..w3
//   rsp_     out        rsp_valid/rsp_stall   data_w0..w3, status, depth
//
// One item is in work at a time. Push, failed checks and unused op codes finish
// at once; pop, narrow pop and dup do one RAM read, then give the result; swap
// passes through more states, since the single RAM port pair needs two reads and two writes.
// Reset clears the entry count and the sequencer; the RAM itself is not cleared.
// A new item is taken only when the result register is empty or being emptied.
`default_nettype none

module evm_operand_stack_unit #(
   parameter int STACK_DEPTH = eos_pkg::DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [eos_pkg::OP_W-1:0]         req_op,
   input  wire logic [eos_pkg::IDX_W-1:0]        req_index,
   input  wire logic [eos_pkg::WORD_W-1:0]       req_value_w0,
   input  wire logic [eos_pkg::WORD_W-1:0]       req_value_w1,
   input  wire logic [eos_pkg::WORD_W-1:0]       req_value_w2,
   input  wire logic [eos_pkg::WORD_W-1:0]       req_value_w3,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [eos_pkg::WORD_W-1:0]            rsp_data_w0,
   output logic [eos_pkg::WORD_W-1:0]            rsp_data_w1,
   output logic [eos_pkg::WORD_W-1:0]            rsp_data_w2,
   output logic [eos_pkg::WORD_W-1:0]            rsp_data_w3,
   output logic [eos_pkg::STATUS_W-1:0]          rsp_status,
   output logic [eos_pkg::DEPTH_W-1:0]           rsp_depth
);

   import eos_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_free;
   logic               res_load;
   result_type         res;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;
   logic [VALUE_W-1:0] req_value;

   assign req_value = {req_value_w3, req_value_w2, req_value_w1, req_value_w0};

   // Stack storage, one 256-bit entry per row.
   eos_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   eos_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (op_type'(req_op)),
      .req_index   (req_index),
      .req_value   (req_value),
      .rsp_free    (rsp_free),
      .res_load    (res_load),
      .res         (res),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Result register: loads a finished item, empties when the item is taken.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data_w0 = rsp_ff.data[0];
   assign rsp_data_w1 = rsp_ff.data[1];
   assign rsp_data_w2 = rsp_ff.data[2];
   assign rsp_data_w3 = rsp_ff.data[3];
   assign rsp_status  = rsp_ff.status;
   assign rsp_depth   = rsp_ff.depth;

   // A new result never lands on one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> rsp_free)
      else $error("result loaded while previous item is still pending");

   // Input is held off while a result is blocked.
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input accepted while output is blocked");

   // Underflow can only be reported on an empty stack.
   a_under_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_UNDER) |-> (rsp_depth == '0))
      else $error("underflow reported with nonzero depth");

   // Any failure carries all-zero data.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
      (rsp_data_w0 == '0 && rsp_data_w1 == '0 && rsp_data_w2 == '0 && rsp_data_w3 == '0))
      else $error("failed item carries nonzero data");

endmodule

`default_nettype wire

### dv/stack_result_checker.sv
// Checker for the operand stack unit: tracks the stack contents and compares every result.
`timescale 1ns / 100ps

module stack_result_checker #(
   parameter int STACK_DEPTH = eos_pkg::DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic [eos_pkg::OP_W-1:0]     req_op,
   input  wire logic [eos_pkg::IDX_W-1:0]    req_index,
   input  wire logic [eos_pkg::WORD_W-1:0]   req_value_w0,
   input  wire logic [eos_pkg::WORD_W-1:0]   req_value_w1,
   input  wire logic [eos_pkg::WORD_W-1:0]   req_value_w2,
   input  wire logic [eos_pkg::WORD_W-1:0]   req_value_w3,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic [eos_pkg::WORD_W-1:0]   rsp_data_w0,
   input  wire logic [eos_pkg::WORD_W-1:0]   rsp_data_w1,
   input  wire logic [eos_pkg::WORD_W-1:0]   rsp_data_w2,
   input  wire logic [eos_pkg::WORD_W-1:0]   rsp_data_w3,
   input  wire logic [eos_pkg::STATUS_W-1:0] rsp_status,
   input  wire logic [eos_pkg::DEPTH_W-1:0]  rsp_depth,
   output int                                failures,
   output int                                outstanding
);

   import eos_pkg::*;

   typedef logic [WORDS-1:0][WORD_W-1:0] stack_word_type;

   // Mirror of the stack contents; entries at or above the count are never read.
   stack_word_type stack_image [STACK_DEPTH];
   int unsigned    entry_total = 0;
   result_type     awaited_results [$];
   int             fail_count = 0;

   // Applies one operation to the mirror and returns the result it must produce.
   function automatic result_type apply_stack_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                                 stack_word_type value);
      result_type     res;
      stack_word_type top_word;
      int unsigned    top_slot;
      int unsigned    far_slot;
      res.data   = '0;
      res.status = ST_OK;
      unique case (op)
         OP_PUSH: begin
            if (entry_total >= STACK_DEPTH) begin
               res.status = ST_OVER;
            end else begin
               stack_image[entry_total] = value;
               entry_total++;
            end
         end
         OP_POP, OP_NARROW: begin
            if (entry_total == 0) begin
               res.status = ST_UNDER;
            end else begin
               // The entry is consumed even when a narrow pop finds it too wide.
               entry_total--;
               top_word = stack_image[entry_total];
               if (op == OP_POP) begin
                  res.data = top_word;
               end else if (top_word[WORDS-1:1] != '0) begin
                  res.status = ST_WIDE;
               end else begin
                  res.data[0] = top_word[0];
               end
            end
         end
         OP_SWAP: begin
            if (idx == 0 || idx >= entry_total) begin
               res.status = ST_INDEX;
            end else begin
               top_slot = entry_total - 1;
               far_slot = top_slot - idx;
               top_word = stack_image[top_slot];
               stack_image[top_slot] = stack_image[far_slot];
               stack_image[far_slot] = top_word;
            end
         end
         OP_DUP: begin
            // The index is checked before the depth limit.
            if (idx >= entry_total) begin
               res.status = ST_INDEX;
            end else if (entry_total >= STACK_DEPTH) begin
               res.status = ST_OVER;
            end else begin
               stack_image[entry_total] = stack_image[entry_total - 1 - idx];
               entry_total++;
            end
         end
         default: begin
            // Unused op codes change nothing.
         end
      endcase
      res.depth = entry_total[DEPTH_W-1:0];
      return res;
   endfunction

   function automatic void note_failure(string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: mismatch: %s", $realtime, what);
      end
   endfunction

   function automatic void check_field(string field, logic [WORD_W-1:0] want,
                                       logic [WORD_W-1:0] got);
      if (want !== got) begin
         note_failure($sformatf("%s expected %h, got %h", field, want, got));
      end
   endfunction

   // Record each accepted item, then compare each accepted result with the oldest one.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         entry_total = 0;
         awaited_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(apply_stack_op(req_op, req_index,
               {req_value_w3, req_value_w2, req_value_w1, req_value_w0}));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               note_failure("result arrived with no item waiting for it");
            end else begin
               want = awaited_results[0];
               awaited_results.delete(0);
               check_field("data_w0", want.data[0], rsp_data_w0);
               check_field("data_w1", want.data[1], rsp_data_w1);
               check_field("data_w2", want.data[2], rsp_data_w2);
               check_field("data_w3", want.data[3], rsp_data_w3);
               check_field("status", WORD_W'(want.status), WORD_W'(rsp_status));
               check_field("depth", WORD_W'(want.depth), WORD_W'(rsp_depth));
            end
         end
      end
      failures    <= fail_count;
      outstanding <= awaited_results.size();
   end

endmodule

### dv/testbench.sv
// Top of the operand stack unit testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module testbench;

   import eos_pkg::*;

   localparam int FULL_DEPTH         = DEPTH_DEFAULT;
   localparam int IDLE_LIMIT         = 3000;
   localparam int RESULT_HOLD_CYCLES = 400;
   localparam int HOLD_AFTER_RESULTS = 250;
   localparam int DRAIN_CYCLES       = 16;

   // Op codes the block has no use for.
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_op;
   logic [IDX_W-1:0]    req_index;
   logic [WORD_W-1:0]   req_value_w0;
   logic [WORD_W-1:0]   req_value_w1;
   logic [WORD_W-1:0]   req_value_w2;
   logic [WORD_W-1:0]   req_value_w3;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [WORD_W-1:0]   rsp_data_w0;
   logic [WORD_W-1:0]   rsp_data_w1;
   logic [WORD_W-1:0]   rsp_data_w2;
   logic [WORD_W-1:0]   rsp_data_w3;
   logic [STATUS_W-1:0] rsp_status;
   logic [DEPTH_W-1:0]  rsp_depth;

   int failures;
   int outstanding;
   int stack_fill    = 0;
   int results_taken = 0;
   int idle_cycles   = 0;
   bit send_burst    = 1'b0;
   bit take_burst    = 1'b0;

   evm_operand_stack_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_index    (req_index),
      .req_value_w0 (req_value_w0),
      .req_value_w1 (req_value_w1),
      .req_value_w2 (req_value_w2),
      .req_value_w3 (req_value_w3),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data_w0  (rsp_data_w0),
      .rsp_data_w1  (rsp_data_w1),
      .rsp_data_w2  (rsp_data_w2),
      .rsp_data_w3  (rsp_data_w3),
      .rsp_status   (rsp_status),
      .rsp_depth    (rsp_depth)
   );

   stack_result_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_index    (req_index),
      .req_value_w0 (req_value_w0),
      .req_value_w1 (req_value_w1),
      .req_value_w2 (req_value_w2),
      .req_value_w3 (req_value_w3),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data_w0  (rsp_data_w0),
      .rsp_data_w1  (rsp_data_w1),
      .rsp_data_w2  (rsp_data_w2),
      .rsp_data_w3  (rsp_data_w3),
      .rsp_status   (rsp_status),
      .rsp_depth    (rsp_depth),
      .failures     (failures),
      .outstanding  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // End the run when neither channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("** evm_operand_stack_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Offers one item after a random gap and returns once it has been taken.
   task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                          input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                          input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3);
      int gap;
      if ($urandom_range(0, 49) == 0) begin
         send_burst = !send_burst;
      end
      gap = draw_wait(send_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_index    <= idx;
      req_value_w0 <= w0;
      req_value_w1 <= w1;
      req_value_w2 <= w2;
      req_value_w3 <= w3;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Rough fill level, used only to steer the indices and the op mix.
      unique case (op)
         OP_PUSH: if (stack_fill < FULL_DEPTH) stack_fill++;
         OP_POP, OP_NARROW: if (stack_fill > 0) stack_fill--;
         OP_DUP: if (idx < stack_fill && stack_fill < FULL_DEPTH) stack_fill++;
         default: begin
         end
      endcase
   endtask

   // One random item; grow_pct sets how often it is a push or a dup.
   task automatic send_random(input int grow_pct);
      int                           pick;
      int                           kind;
      logic [OP_W-1:0]              op;
      logic [IDX_W-1:0]             idx;
      logic [WORDS-1:0][WORD_W-1:0] value;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else if (pick < grow_pct) begin
         op = ($urandom_range(0, 3) == 0) ? OP_DUP : OP_PUSH;
      end else begin
         kind = $urandom_range(0, 2);
         op = (kind == 0) ? OP_POP : (kind == 1) ? OP_NARROW : OP_SWAP;
      end

      // Mostly indices that reach a live entry, sometimes any index or the first one past it.
      if (stack_fill == 0 || $urandom_range(0, 6) == 0) begin
         idx = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom) : IDX_W'(stack_fill);
      end else begin
         idx = IDX_W'($urandom_range(0, stack_fill - 1));
      end

      // Narrow values give narrow pops a chance to succeed; single high bits test the limit.
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         value    = '0;
         value[0] = random_word();
      end else if (kind == 4) begin
         value    = '0;
         value[0] = random_word();
         value[$urandom_range(1, WORDS - 1)][$urandom_range(0, WORD_W - 1)] = 1'b1;
      end else if (kind == 5) begin
         value = '1;
      end else begin
         value = {random_word(), random_word(), random_word(), random_word()};
      end
      send_op(op, idx, value[0], value[1], value[2], value[3]);
   endtask

   // Stimulus and verdict.
   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_op       <= OP_PUSH;
      req_index    <= '0;
      req_value_w0 <= '0;
      req_value_w1 <= '0;
      req_value_w2 <= '0;
      req_value_w3 <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Everything that can go wrong on an empty stack.
      send_op(OP_POP, '0, '0, '0, '0, '0);
      send_op(OP_NARROW, '0, '0, '0, '0, '0);
      send_op(OP_SWAP, '0, '0, '0, '0, '0);
      send_op(OP_DUP, '0, '0, '0, '0, '0);
      // Widest value, a full 64-bit value, and values with only bit 255 or bit 64 set.
      send_op(OP_PUSH, '0, '1, '1, '1, '1);
      send_op(OP_PUSH, '1, '1, '0, '0, '0);
      send_op(OP_PUSH, '0, '0, '0, '0, 64'h8000_0000_0000_0000);
      send_op(OP_PUSH, '0, '0, 64'h1, '0, '0);
      // A narrow pop of a wide value still removes it.
      send_op(OP_NARROW, '0, '0, '0, '0, '0);
      // Swap with the top itself, the deepest entry, one past it and the largest index.
      send_op(OP_SWAP, '0, '0, '0, '0, '0);
      send_op(OP_SWAP, IDX_W'(2), '0, '0, '0, '0);
      send_op(OP_SWAP, IDX_W'(3), '0, '0, '0, '0);
      send_op(OP_SWAP, '1, '0, '0, '0, '0);
      // Dup of the deepest entry, then indices past the depth.
      send_op(OP_DUP, IDX_W'(2), '0, '0, '0, '0);
      send_op(OP_DUP, IDX_W'(4), '0, '0, '0, '0);
      send_op(OP_DUP, '1, '0, '0, '0, '0);
      // Unused op codes.
      send_op(OP_UNUSED_LO, '0, '1, '1, '1, '1);
      send_op(OP_UNUSED_HI, '1, '0, '0, '0, '0);
      // Plain pop, a narrow pop that fits, then empty the stack and pop once more.
      send_op(OP_POP, '0, '0, '0, '0, '0);
      send_op(OP_PUSH, '0, 64'h0123_4567_89AB_CDEF, '0, '0, '0);
      send_op(OP_NARROW, '0, '0, '0, '0, '0);
      repeat (4) send_op(OP_POP, '0, '0, '0, '0, '0);

      // Random work near the bottom, a climb to the depth limit, then churn while full.
      repeat (40) send_random(45);
      while (stack_fill < FULL_DEPTH) send_random(97);
      repeat (50) send_random(70);
      req_valid <= 1'b0;

      // Let the checker count the last item before waiting for the results to drain.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("** evm_operand_stack_unit: PASSED **");
      end else begin
         $display("** evm_operand_stack_unit: FAILED **");
      end
      $finish;
   end

   // Result receiver: random stalls, bursts without stalls, and one long hold-off.
   initial begin
      int gap;
      rsp_stall <= 1'b1;
      @(posedge clock iff !reset);
      forever begin
         if ($urandom_range(0, 49) == 0) begin
            take_burst = !take_burst;
         end
         gap = (results_taken == HOLD_AFTER_RESULTS) ? RESULT_HOLD_CYCLES
                                                     : draw_wait(take_burst);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_taken++;
      end
   end

endmodule

### files.f
design/eos_pkg.sv
design/eos_ram.sv
design/eos_ctrl.sv
design/evm_operand_stack_unit.sv
dv/stack_result_checker.sv
dv/testbench.sv
